>>> design/rprd_pkg.sv
// shared types, codes and helpers for the repeat press/release detector
`default_nettype none

package rprd_pkg;

  // nibble limit of a fingerprint
  localparam int MAX_NIBBLES = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

  // register reset values
  localparam logic [31:0] WINDOW_RESET    = 32'd250000;
  localparam logic [7:0]  MIN_COUNT_RESET = 8'd2;
  localparam logic [1:0]  MODE_RESET      = 2'd2;

  // command codes
  localparam logic CMD_OFFER  = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  // forward modes
  localparam logic [1:0] MODE_LAST_ONLY   = 2'd0;
  localparam logic [1:0] MODE_SECOND_ONLY = 2'd1;

  // event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;

  // input word
  typedef struct packed {
    logic        command;
    logic [63:0] fingerprint;
    logic [4:0]  nibble_count;
    logic [31:0] now_us;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] repeat_total;
    logic [31:0] gap_us;
    logic [63:0] out_fingerprint;
    logic [4:0]  out_nibble_count;
  } out_word_t;

  // one ring entry as kept in the ram
  typedef struct packed {
    logic [63:0] fp;
    logic [4:0]  nc;
    logic [31:0] stamp;
    logic [15:0] repeats;
    logic [31:0] gap;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } rprd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_valid;
    logic hit;
    logic last;
    logic out_free;
  } rprd_stat_t;

  // clamp an oversized nibble count
  function automatic logic [4:0] clamp_nc(input logic [4:0] nc);
    if (nc > 5'(MAX_NIBBLES)) begin
      return 5'(MAX_NIBBLES);
    end
    return nc;
  endfunction

  // mask covering the valid nibbles
  function automatic logic [63:0] nib_mask(input logic [4:0] nc);
    if (nc >= 5'd16) begin
      return '1;
    end
    return (64'd1 << {nc[3:0], 2'b00}) - 64'd1;
  endfunction

endpackage

`default_nettype wire

>>> design/rprd_stream_if.sv
// handshake channels for telegram and report words
`default_nettype none

interface rprd_telegram_if;
  import rprd_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rprd_report_if;
  import rprd_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/rprd_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module rprd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/rprd_ctrl.sv
// sequencing state machine: accept, ring scan, update and report
`default_nettype none

module rprd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                telegram_valid,
  output logic                     telegram_ready,
  input  wire rprd_pkg::rprd_stat_t st,
  output rprd_pkg::rprd_cmd_t      cmd
);
  import rprd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (telegram_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.eval_valid && (st.hit || st.last)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands
  assign telegram_ready = (state == S_IDLE);
  assign cmd.start      = (state == S_IDLE) && telegram_valid;
  assign cmd.scan       = (state == S_SCAN);
  assign cmd.finish     = ((state == S_DONE) || (state == S_HOLD)) && st.out_free;

  // scan always ends on a hit or on the last entry
  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && st.eval_valid && st.last |=> (state == S_DONE))
    else $error("scan ran past the last ring entry");

  // an accepted word always starts a scan
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_SCAN) && !telegram_ready)
    else $error("accepted word did not start a scan");

endmodule

`default_nettype wire

>>> design/rprd_dp.sv
// ring storage, match and expiry evaluation, update and report register
`default_nettype none

module rprd_dp #(
  parameter int RING_ENTRIES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rprd_pkg::in_word_t                  in_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output rprd_pkg::out_word_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [rprd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rprd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire rprd_pkg::rprd_cmd_t                 cmd,
  output rprd_pkg::rprd_stat_t                     st
);
  import rprd_pkg::*;

  localparam int PTR_W = $clog2(RING_ENTRIES);
  localparam logic [PTR_W-1:0] IDX_LAST = PTR_W'(RING_ENTRIES - 1);

  // configuration
  logic [31:0] window;
  logic [7:0]  min_count;
  logic [1:0]  mode;

  // latched word
  logic        cmd_q;
  logic [63:0] fp_q;
  logic [4:0]  nc_q;
  logic [31:0] now_q;

  // per-entry flags
  logic [RING_ENTRIES-1:0] occ;
  logic [RING_ENTRIES-1:0] fwd;
  logic [RING_ENTRIES-1:0] rel;
  logic [PTR_W-1:0]        wp;

  // scan
  logic [PTR_W-1:0] rd_idx;
  logic [PTR_W-1:0] eval_idx;
  logic             eval_valid;
  logic             found_q;
  logic [PTR_W-1:0] found_idx;
  slot_t            held;

  // ram ports
  logic [$bits(slot_t)-1:0] rdata;
  slot_t                    rslot;
  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  slot_t                    ram_wslot;

  // evaluation
  logic        live;
  logic [31:0] diff;
  logic        in_window;
  logic        offer_hit;
  logic        expired;
  logic        qual;
  logic        hit;
  logic        retire;

  // update
  logic [4:0]  nc_in;
  logic [15:0] rep_new;
  logic [31:0] gap_new;
  logic        fire;
  out_word_t   word_next;

  assign nc_in = clamp_nc(in_data.nibble_count);

  rprd_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (RING_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .re    (cmd.scan),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  assign rslot = slot_t'(rdata);

  // match and expiry of the entry now read back
  always_comb begin
    live      = occ[eval_idx] && !rel[eval_idx];
    diff      = now_q - rslot.stamp;
    in_window = (diff <= window);
    offer_hit = live && in_window && (rslot.nc == nc_q) && (rslot.fp == fp_q);
    expired   = live && !in_window;
    qual      = (mode != MODE_SECOND_ONLY) && (rslot.repeats >= {8'd0, min_count});
    if (cmd_q == CMD_OFFER) begin
      hit = eval_valid && offer_hit;
    end else begin
      hit = eval_valid && expired && qual;
    end
    retire = eval_valid && (cmd_q == CMD_EXPIRE) && expired && !qual;
  end

  assign st.eval_valid = eval_valid;
  assign st.hit        = hit;
  assign st.last       = (eval_idx == IDX_LAST);
  assign st.out_free   = !out_valid || out_ready;

  // update values and the report word
  always_comb begin
    rep_new   = (held.repeats == 16'hFFFF) ? held.repeats : held.repeats + 16'd1;
    gap_new   = now_q - held.stamp;
    fire      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wslot = '{fp: fp_q, nc: nc_q, stamp: now_q, repeats: 16'd1, gap: 32'd0};
    word_next = '0;
    if (cmd_q == CMD_OFFER) begin
      ram_we = cmd.finish;
      if (found_q) begin
        fire      = (mode != MODE_LAST_ONLY) && !fwd[found_idx] &&
                    (rep_new >= {8'd0, min_count});
        ram_waddr = found_idx;
        ram_wslot = '{fp: held.fp, nc: held.nc, stamp: now_q, repeats: rep_new,
                      gap: gap_new};
        word_next = '{event_res: fire ? EV_PRESSED : EV_NONE, repeat_total: rep_new,
                      gap_us: gap_new, out_fingerprint: fp_q, out_nibble_count: nc_q};
      end else begin
        fire      = (mode != MODE_LAST_ONLY) && (min_count <= 8'd1);
        word_next = '{event_res: fire ? EV_PRESSED : EV_NONE, repeat_total: 16'd1,
                      gap_us: 32'd0, out_fingerprint: fp_q, out_nibble_count: nc_q};
      end
    end else if (found_q) begin
      word_next = '{event_res: EV_RELEASED, repeat_total: held.repeats,
                    gap_us: held.gap, out_fingerprint: held.fp,
                    out_nibble_count: held.nc};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RESET;
      min_count <= MIN_COUNT_RESET;
      mode      <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW:    window    <= cfg_data;
        REG_MIN_COUNT: min_count <= cfg_data[7:0];
        REG_MODE:      mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_q <= in_data.command;
      nc_q  <= nc_in;
      fp_q  <= in_data.fingerprint & nib_mask(nc_in);
      now_q <= in_data.now_us;
    end
  end

  // scan pointers and the captured entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      eval_valid <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd.start) begin
      rd_idx     <= '0;
      eval_valid <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd.scan) begin
      rd_idx     <= (rd_idx == IDX_LAST) ? '0 : rd_idx + PTR_W'(1);
      eval_valid <= 1'b1;
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      eval_idx <= rd_idx;
      if (hit) begin
        found_idx <= eval_idx;
        held      <= rslot;
      end
    end
  end

  // entry flags and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      fwd <= '0;
      rel <= '0;
      wp  <= '0;
    end else if (cmd.scan) begin
      if (retire) begin
        occ[eval_idx] <= 1'b0;
      end
    end else if (cmd.finish) begin
      if (cmd_q == CMD_OFFER) begin
        if (found_q) begin
          if (fire) begin
            fwd[found_idx] <= 1'b1;
          end
        end else begin
          occ[wp] <= (nc_q != 5'd0);
          fwd[wp] <= fire;
          rel[wp] <= 1'b0;
          wp      <= (wp == IDX_LAST) ? '0 : wp + PTR_W'(1);
        end
      end else if (found_q) begin
        rel[found_idx] <= 1'b1;
      end
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= word_next;
    end
  end

  // a report never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("report register overwritten");

  // a release on expire is reported as released
  a_release_word: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && (cmd_q == CMD_EXPIRE) && found_q |=>
      out_valid && (out_data.event_res == EV_RELEASED))
    else $error("release not reported");

  // write pointer stays inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= IDX_LAST)
    else $error("write pointer out of range");

endmodule

`default_nettype wire

>>> design/repeat_press_release_detector_core.sv
// Repeat press/release detector: top level joining controller and datapath.
//
// telegram channel: one word per command. command 0 offers a decoded
// fingerprint, command 1 asks for an expired entry to be released.
// report channel: exactly one word for every telegram word.
// Configuration: cfg_we with cfg_index selects window (0), minimum count (1)
// and forward mode (2); write only while the block is idle.
// A scan runs over the ring from acceptance and ends early on a match or release,
// else after the last entry; the report register then takes the result. The ring is
// read one entry per cycle through the registered read port of the slot ram, and a
// new telegram word is taken only once the scan for the previous one has ended.
// A new telegram word is taken while a finished report still waits; the
// following result then holds until the report is taken.
// Reset empties the ring (per-entry live, forwarded and released flags clear at
// once, no sweep), zeroes the write pointer and loads the register defaults.
`default_nettype none

module repeat_press_release_detector_core #(
  parameter int RING_ENTRIES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  rprd_telegram_if.sink                            telegram,
  rprd_report_if.source                            report,
  input  wire logic                                cfg_we,
  input  wire logic [rprd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rprd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rprd_pkg::*;

  rprd_cmd_t  cmd;
  rprd_stat_t st;
  logic       ready_int;
  logic       rep_valid;
  out_word_t  rep_data;

  rprd_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .telegram_valid (telegram.valid),
    .telegram_ready (ready_int),
    .st             (st),
    .cmd            (cmd)
  );

  rprd_dp #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (telegram.data),
    .out_ready (report.ready),
    .out_valid (rep_valid),
    .out_data  (rep_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

  // channel hookup
  assign telegram.ready = ready_int;
  assign report.valid   = rep_valid;
  assign report.data    = rep_data;

endmodule

`default_nettype wire

>>> sim/tb.sv
// testbench for the repeat press/release detector core: scoreboard, traffic and checks
`timescale 1ns / 1ps

module tb;
  import rprd_pkg::*;

  localparam int RING_ENTRIES = 8;
  localparam int POOL = 6;
  localparam int STALL_LIMIT = 3000;
  localparam int QUIET_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;

  // forward modes without a name in the package
  localparam logic [1:0] MODE_BOTH  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // register settings stepped through by the random traffic
  localparam logic [31:0] PHASE_WINDOW [6] = '{32'd250000, 32'd0, 32'd1000,
                                               32'hFFFF_FFFF, 32'd5000, 32'd20000};
  localparam logic [7:0]  PHASE_MIN [6]    = '{8'd2, 8'd0, 8'd1, 8'd255, 8'd3, 8'd2};
  localparam logic [1:0]  PHASE_MODE [6]   = '{MODE_BOTH, MODE_LAST_ONLY, MODE_SECOND_ONLY,
                                               MODE_SPARE, MODE_BOTH, MODE_LAST_ONLY};

  // ring tracker and store of due report words
  class press_release_scoreboard;
    localparam int SLOTS = 8;
    localparam logic [15:0] REPEAT_CEIL = 16'hFFFF;

    logic [31:0] window;
    logic [7:0]  min_count;
    logic [1:0]  mode;
    logic [63:0] ring_fp [SLOTS];
    logic [4:0]  ring_nc [SLOTS];
    logic [31:0] ring_stamp [SLOTS];
    logic [15:0] ring_repeats [SLOTS];
    logic [31:0] ring_gap [SLOTS];
    bit          ring_fwd [SLOTS];
    bit          ring_released [SLOTS];
    int          head;
    out_word_t   reports_due [$];
    int mismatches, checked, offers, expires, pressed, released;

    function new();
      window = WINDOW_RESET;
      min_count = MIN_COUNT_RESET;
      mode = MODE_RESET;
      head = 0;
      for (int i = 0; i < SLOTS; i++) begin
        ring_fp[i] = '0;
        ring_nc[i] = '0;
        ring_stamp[i] = '0;
        ring_repeats[i] = '0;
        ring_gap[i] = '0;
        ring_fwd[i] = 1'b0;
        ring_released[i] = 1'b0;
      end
      mismatches = 0;
      checked = 0;
      offers = 0;
      expires = 0;
      pressed = 0;
      released = 0;
    endfunction

    function logic [63:0] lane_mask(logic [4:0] nc);
      if (nc >= 5'(MAX_NIBBLES)) begin
        return '1;
      end
      return ~(64'hFFFF_FFFF_FFFF_FFFF << {nc, 2'b00});
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WINDOW:    window = value;
        REG_MIN_COUNT: min_count = value[7:0];
        REG_MODE:      mode = value[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    // work out the report word for one accepted telegram word
    function void note_telegram(in_word_t w);
      out_word_t r;
      logic [4:0]  nc;
      logic [63:0] fp;
      logic [31:0] age;
      int found;
      r = '0;
      found = -1;
      if (w.command == CMD_OFFER) begin
        offers++;
        nc = (w.nibble_count > 5'(MAX_NIBBLES)) ? 5'(MAX_NIBBLES) : w.nibble_count;
        fp = w.fingerprint & lane_mask(nc);
        // first live, unreleased, in-window entry with the same fingerprint
        for (int i = 0; i < SLOTS; i++) begin
          age = w.now_us - ring_stamp[i];
          if (found < 0 && ring_nc[i] != 5'd0 && !ring_released[i] && age <= window &&
              ring_nc[i] == nc && ring_fp[i] == fp) begin
            found = i;
          end
        end
        if (found >= 0) begin
          if (ring_repeats[found] != REPEAT_CEIL) begin
            ring_repeats[found]++;
          end
          ring_gap[found] = w.now_us - ring_stamp[found];
          ring_stamp[found] = w.now_us;
          r.event_res = EV_NONE;
          if (mode != MODE_LAST_ONLY && !ring_fwd[found] &&
              ring_repeats[found] >= {8'd0, min_count}) begin
            ring_fwd[found] = 1'b1;
            r.event_res = EV_PRESSED;
          end
          r.repeat_total = ring_repeats[found];
          r.gap_us = ring_gap[found];
        end else begin
          // miss: overwrite the slot at head
          ring_fp[head] = fp;
          ring_nc[head] = nc;
          ring_stamp[head] = w.now_us;
          ring_repeats[head] = 16'd1;
          ring_gap[head] = '0;
          ring_fwd[head] = 1'b0;
          ring_released[head] = 1'b0;
          r.event_res = EV_NONE;
          if (mode != MODE_LAST_ONLY && min_count <= 8'd1) begin
            ring_fwd[head] = 1'b1;
            r.event_res = EV_PRESSED;
          end
          r.repeat_total = 16'd1;
          r.gap_us = '0;
          head = (head + 1) % SLOTS;
        end
        r.out_fingerprint = fp;
        r.out_nibble_count = nc;
      end else begin
        expires++;
        // release the first qualifying expired entry, retire the ones passed over
        for (int i = 0; i < SLOTS; i++) begin
          age = w.now_us - ring_stamp[i];
          if (found < 0 && ring_nc[i] != 5'd0 && !ring_released[i] && age > window) begin
            if (mode != MODE_SECOND_ONLY && ring_repeats[i] >= {8'd0, min_count}) begin
              found = i;
              ring_released[i] = 1'b1;
              r.event_res = EV_RELEASED;
              r.repeat_total = ring_repeats[i];
              r.gap_us = ring_gap[i];
              r.out_fingerprint = ring_fp[i];
              r.out_nibble_count = ring_nc[i];
            end else begin
              ring_nc[i] = 5'd0;
            end
          end
        end
      end
      if (r.event_res == EV_PRESSED) pressed++;
      if (r.event_res == EV_RELEASED) released++;
      reports_due.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      // only the first few are shown, all are counted
      if (mismatches < 40) begin
        $display("mismatch at report word %0d: %s got %0h expected %0h",
                 checked, what, got, want);
      end
      mismatches++;
    endtask

    // compare one accepted report word with the oldest due one
    task check_report(out_word_t got);
      out_word_t want;
      if (reports_due.size() == 0) begin
        report_mismatch("report word with none due", got.out_fingerprint, '0);
      end else begin
        want = reports_due.pop_front();
        if (got.event_res != want.event_res)
          report_mismatch("event_res", got.event_res, want.event_res);
        if (got.repeat_total != want.repeat_total)
          report_mismatch("repeat_total", got.repeat_total, want.repeat_total);
        if (got.gap_us != want.gap_us)
          report_mismatch("gap_us", got.gap_us, want.gap_us);
        if (got.out_fingerprint != want.out_fingerprint)
          report_mismatch("out_fingerprint", got.out_fingerprint, want.out_fingerprint);
        if (got.out_nibble_count != want.out_nibble_count)
          report_mismatch("out_nibble_count", got.out_nibble_count, want.out_nibble_count);
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rprd_telegram_if telegram_ch ();
  rprd_report_if   report_ch ();

  press_release_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int n_sent = 0;
  logic [31:0] clock_us = '0;
  logic [63:0] pool_fp [POOL];
  logic [4:0]  pool_nc [POOL];

  repeat_press_release_detector_core #(
    .RING_ENTRIES(RING_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .telegram(telegram_ch),
    .report(report_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // report side: random ready, long hold-off on request, checking
  initial begin
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (report_ch.valid && report_ch.ready) sb.check_report(report_ch.data);
        if (hold_left > 0) begin
          hold_left--;
          report_ch.ready <= 1'b0;
        end else begin
          report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
      end
    end
  end

  // cycles since the last word moved on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((telegram_ch.valid && telegram_ch.ready) || (report_ch.valid && report_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("repeat_press_release_detector_core test failed");
    $finish;
  end

  // offer one telegram word, valid stays high afterwards unless a gap follows
  task send_word(in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      telegram_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    telegram_ch.valid <= 1'b1;
    telegram_ch.data <= w;
    do @(posedge clk); while (!telegram_ch.ready);
    sb.note_telegram(w);
    n_sent++;
  endtask

  task offer(logic [63:0] fp, logic [4:0] nc, logic [31:0] t);
    in_word_t w;
    w.command = CMD_OFFER;
    w.fingerprint = fp;
    w.nibble_count = nc;
    w.now_us = t;
    send_word(w);
  endtask

  // unused fields carry noise
  task expire_check(logic [31:0] t);
    in_word_t w;
    w.command = CMD_EXPIRE;
    w.fingerprint = {$urandom, $urandom};
    w.nibble_count = 5'($urandom_range(31));
    w.now_us = t;
    send_word(w);
  endtask

  task drain_reports();
    telegram_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task set_config(logic [31:0] window, logic [7:0] min_count, logic [1:0] mode);
    drain_reports();
    repeat (QUIET_CYCLES) @(posedge clk);
    write_reg(REG_WINDOW, window);
    write_reg(REG_MIN_COUNT, {24'd0, min_count});
    write_reg(REG_MODE, {30'd0, mode});
    cfg_we <= 1'b0;
  endtask

  // known fingerprint with fresh junk above its nibbles, oversized counts now and then
  task pool_offer(int p);
    logic [4:0]  nc;
    logic [63:0] m;
    nc = pool_nc[p];
    if (nc == 5'(MAX_NIBBLES) && $urandom_range(1) == 1) nc = 5'($urandom_range(31, 16));
    m = sb.lane_mask(nc);
    offer((pool_fp[p] & m) | ({$urandom, $urandom} & ~m), nc, clock_us);
  endtask

  function automatic logic [31:0] step_within();
    logic [31:0] cap;
    if (sb.window == 32'd0) return 32'd0;
    cap = (sb.window > 32'd200000) ? 32'd200000 : sb.window;
    return $urandom_range(cap, 0);
  endfunction

  function automatic logic [31:0] step_beyond();
    if (sb.window == 32'hFFFF_FFFF) return $urandom_range(1000);
    if (sb.window > 32'hFFFF_0000) return sb.window + 32'd1;
    return sb.window + 32'd1 + $urandom_range(2000);
  endfunction

  // mostly repeat bursts and expiry checks, some noise
  task run_traffic(int count);
    int goal, kind, p;
    goal = n_sent + count;
    while (n_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        p = $urandom_range(POOL - 1);
        repeat ($urandom_range(6, 1)) begin
          clock_us += step_within();
          if ($urandom_range(3) == 0) pool_offer($urandom_range(POOL - 1));
          pool_offer(p);
        end
      end else if (kind < 80) begin
        clock_us += step_beyond();
        repeat ($urandom_range(3, 1)) expire_check(clock_us);
      end else if (kind < 88) begin
        offer({$urandom, $urandom}, 5'($urandom_range(31)), $urandom);
      end else if (kind < 94) begin
        expire_check($urandom);
      end else if (kind < 97) begin
        clock_us = $urandom;
      end else begin
        p = $urandom_range(POOL - 1);
        pool_fp[p] = {$urandom, $urandom};
        pool_nc[p] = 5'($urandom_range(MAX_NIBBLES));
      end
    end
  endtask

  initial begin
    logic [63:0] fp_a, fp_b;
    telegram_ch.valid <= 1'b0;
    telegram_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data <= '0;
    rst <= 1'b1;
    for (int i = 0; i < POOL; i++) begin
      pool_fp[i] = {$urandom, $urandom};
      pool_nc[i] = 5'($urandom_range(MAX_NIBBLES));
    end
    pool_nc[0] = 5'(MAX_NIBBLES);
    fp_a = {$urandom, $urandom};
    fp_b = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 53;

    // directed: defaults, masking, oversized and empty offers, release order
    set_config(WINDOW_RESET, MIN_COUNT_RESET, MODE_BOTH);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 32'd0);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 32'd100);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 32'd200);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 32'd300);
    offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 32'd400);
    offer(64'hFFFF_FFFF_FFFF_FFF5, 5'd1, 32'd500);
    offer(64'h5, 5'd1, 32'd600);
    expire_check(32'd700);
    expire_check(32'd250601);
    expire_check(32'd250601);
    expire_check(32'd250601);

    // zero window, last only, wrap of the time counter
    set_config(32'd0, 8'd0, MODE_LAST_ONLY);
    offer(64'h0, 5'd16, 32'hFFFF_FFF0);
    offer(64'h0, 5'd16, 32'hFFFF_FFF0);
    expire_check(32'h10);

    // widest window, second only with a threshold of one
    set_config(32'hFFFF_FFFF, 8'd1, MODE_SECOND_ONLY);
    offer(fp_a, 5'd8, 32'hFFFF_FFF0);
    offer(fp_a, 5'd8, 32'h10);
    expire_check(32'h8000_0000);

    // second only never releases, expired entries get retired
    set_config(32'd10, 8'd1, MODE_SECOND_ONLY);
    expire_check(32'd1000);
    offer(fp_a, 5'd8, 32'd1000);

    // spare mode value with the highest threshold
    set_config(32'd10, 8'd255, MODE_SPARE);
    offer(fp_b, 5'd3, 32'd2000);
    offer(fp_b, 5'd3, 32'd2005);
    expire_check(32'd3000);

    // random traffic over the register settings and idling schemes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 53;
      end else if (ph < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(PHASE_WINDOW[ph], PHASE_MIN[ph], PHASE_MODE[ph]);
      // report side holds off while words keep coming, so the input backs up
      if (ph == 1 || ph == 4) hold_left = HOLD_CYCLES;
      run_traffic(90);
      drain_reports();
      run_traffic(90);
    end

    drain_reports();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("report words still due", sb.pending(), 0);

    $display("covered %0d telegram words: %0d offers, %0d expiry checks, %0d report words",
             n_sent, sb.offers, sb.expires, sb.checked);
    $display("%0d pressed and %0d released events over directed and random settings, %0d mismatches",
             sb.pressed, sb.released, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("repeat_press_release_detector_core test passed");
    end else begin
      $display("repeat_press_release_detector_core test failed");
    end
    $finish;
  end

endmodule

>>> repeat_press_release_detector_core.f
design/rprd_pkg.sv
design/rprd_stream_if.sv
design/rprd_ram.sv
design/rprd_ctrl.sv
design/rprd_dp.sv
design/repeat_press_release_detector_core.sv
sim/tb.sv
